@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define RFIA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define RFIA_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ hw/rtl/rfia_pkg.sv @@
// Package for the range first-index-at-most block: request and result types,
// field widths, action codes and sequencer states. Depends on nothing.
package rfia_pkg;

	localparam int IDX_W = 10;
	localparam int END_W = 11;
	localparam int DATA_W = 32;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic                     action;
		logic [IDX_W-1:0]         element_index;
		logic signed [DATA_W-1:0] element_value;
		logic [IDX_W-1:0]         range_start;
		logic [END_W-1:0]         range_end;
		logic signed [DATA_W-1:0] threshold;
	} req_t;

	typedef struct packed {
		logic                     found;
		logic [IDX_W-1:0]         first_index;
		logic signed [DATA_W-1:0] range_min;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BUILD,
		ST_GAP,
		ST_ISSUE,
		ST_DATA,
		ST_FOLD
	} state_t;

endpackage

@@ hw/rtl/rfia_cmp.sv @@
// Shared signed compare unit: reports a <= b and the smaller operand.
// Used for table rebuild, range minimum folding and threshold tests.
module rfia_cmp #(
	parameter int W = 32
) (
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic                le,
	output logic signed [W-1:0] min
);

	assign le  = (a <= b);
	assign min = le ? a : b;

endmodule

@@ hw/rtl/range_first_index_at_most.sv @@
// Top level of the range first-index-at-most block: sparse table memory,
// sequencer and query datapath. Depends on rfia_pkg and rfia_cmp.
//
//   channel   ports                  direction  handshake
//   request   start, busy, request   in         taken when start=1 and busy=0
//   result    done, result           out        one-cycle strobe, no backpressure
//
// A write request never raises busy and marks the table stale.
// A query on an empty range answers in the next cycle. Otherwise a stale table is
// rebuilt first, one entry per cycle plus a gap state per level (DEPTH-2**k+1 entries
// at level k), then the levels are descended from the top one down to level 0;
// the receiver cannot stall results.
// Reset returns the sequencer to idle and marks the table stale.
module range_first_index_at_most
	import rfia_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t result
);

	localparam int AW = $clog2(DEPTH);
	localparam int PW = $clog2(DEPTH + 1);
	localparam int LOG = PW - 1;
	localparam int LEVELS = PW;
	localparam int LW = $clog2(LEVELS);
	localparam int ADDR_W = $clog2(LEVELS * DEPTH);
	localparam int CW = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;

	// Level k holds the minima of windows of 2**k elements; level 0 is the array.
	logic signed [VALUE_WIDTH-1:0] tbl_mem [LEVELS*DEPTH];
	logic signed [VALUE_WIDTH-1:0] rda_q, rdb_q;

	state_t state_q, state_d;
	logic stale_q, wr_pend_q, done_q, a_pend_q, b_pend_q, min_vld_q;

	logic [LW-1:0]        lvl_q, qlvl_q;
	logic [AW-1:0]        idx_q;
	logic [ADDR_W-1:0]    wr_addr_q;
	logic [PW-1:0]        e_q, pos_min_q, pos_dsc_q;
	logic signed [CW-1:0] thr_q, min_q;
	rsp_t                 result_q;

	logic                          acc, acc_wr, acc_qry, empty;
	logic [PW-1:0]                 s_sat, e_sat, step, half, last_idx;
	logic                          a_take, b_take, last_i;
	logic                          rea, reb, mem_we;
	logic [ADDR_W-1:0]             addr_a, addr_b, mem_waddr;
	logic signed [VALUE_WIDTH-1:0] mem_wdata;
	logic signed [CW-1:0]          cmp_a, cmp_b, cmp_min;
	logic                          cmp_le;

	function automatic logic [ADDR_W-1:0] tbl_addr(input logic [LW-1:0] lv,
			input logic [AW-1:0] ix);
		return ADDR_W'(lv) * ADDR_W'(DEPTH) + ADDR_W'(ix);
	endfunction

	rfia_cmp #(.W(CW)) u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.le  (cmp_le),
		.min (cmp_min)
	);

	assign acc     = start && !busy;
	assign acc_wr  = acc && (request.action == ACT_WRITE);
	assign acc_qry = acc && (request.action == ACT_QUERY);
	assign s_sat   = (32'(request.range_start) > DEPTH) ? PW'(DEPTH)
	                                                    : PW'(request.range_start);
	assign e_sat   = (32'(request.range_end) > DEPTH) ? PW'(DEPTH)
	                                                  : PW'(request.range_end);
	assign empty   = (s_sat >= e_sat);

	assign step     = PW'(1) << qlvl_q;
	assign half     = PW'(1) << (lvl_q - LW'(1));
	assign last_idx = PW'(DEPTH) - (PW'(1) << lvl_q);
	assign last_i   = (PW'(idx_q) == last_idx);
	assign a_take   = ({1'b0, pos_min_q} + {1'b0, step}) <= {1'b0, e_q};
	assign b_take   = ({1'b0, pos_dsc_q} + {1'b0, step}) <= {1'b0, e_q};

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	always_comb begin
		state_d = state_q;
		rea     = 1'b0;
		reb     = 1'b0;
		addr_a  = tbl_addr(qlvl_q, AW'(pos_min_q));
		addr_b  = tbl_addr(qlvl_q, AW'(pos_dsc_q));
		cmp_a   = CW'(rda_q);
		cmp_b   = CW'(rdb_q);
		case (state_q)
			ST_IDLE: begin
				if (acc_qry && !empty) begin
					state_d = stale_q ? ST_BUILD : ST_ISSUE;
				end
			end
			ST_BUILD: begin
				rea    = 1'b1;
				reb    = 1'b1;
				addr_a = tbl_addr(lvl_q - LW'(1), idx_q);
				addr_b = tbl_addr(lvl_q - LW'(1), AW'(PW'(idx_q) + half));
				if (last_i) begin
					state_d = ST_GAP;
				end
			end
			ST_GAP: begin
				state_d = (lvl_q == LW'(LOG)) ? ST_ISSUE : ST_BUILD;
			end
			ST_ISSUE: begin
				rea     = a_take;
				reb     = b_take;
				cmp_b   = min_vld_q ? min_q : CW'(rda_q);
				state_d = ST_DATA;
			end
			ST_DATA: begin
				cmp_a   = CW'(rdb_q);
				cmp_b   = thr_q;
				state_d = (qlvl_q == '0) ? ST_FOLD : ST_ISSUE;
			end
			ST_FOLD: begin
				cmp_b   = min_vld_q ? min_q : CW'(rda_q);
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// User writes land in level 0; rebuild writes follow their reads in the next cycle.
	assign mem_we    = (acc_wr && (32'(request.element_index) < DEPTH)) || wr_pend_q;
	assign mem_waddr = wr_pend_q ? wr_addr_q
	                             : tbl_addr(LW'(0), AW'(request.element_index));
	assign mem_wdata = wr_pend_q ? VALUE_WIDTH'(cmp_min)
	                             : VALUE_WIDTH'(request.element_value);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem[mem_waddr] <= mem_wdata;
		end
		if (rea) begin
			rda_q <= tbl_mem[addr_a];
		end
		if (reb) begin
			rdb_q <= tbl_mem[addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			stale_q   <= 1'b1;
			wr_pend_q <= 1'b0;
			done_q    <= 1'b0;
			a_pend_q  <= 1'b0;
			b_pend_q  <= 1'b0;
			min_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			done_q    <= 1'b0;
			wr_pend_q <= (state_q == ST_BUILD);
			case (state_q)
				ST_IDLE: begin
					if (acc_wr) begin
						stale_q <= 1'b1;
					end
					if (acc_qry) begin
						a_pend_q  <= 1'b0;
						min_vld_q <= 1'b0;
						done_q    <= empty;
					end
				end
				ST_GAP: begin
					if (lvl_q == LW'(LOG)) begin
						stale_q <= 1'b0;
					end
				end
				ST_ISSUE: begin
					if (a_pend_q) begin
						min_vld_q <= 1'b1;
					end
					a_pend_q <= a_take;
					b_pend_q <= b_take;
				end
				ST_FOLD: begin
					done_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc_qry) begin
					e_q       <= e_sat;
					thr_q     <= CW'(request.threshold);
					pos_min_q <= s_sat;
					pos_dsc_q <= s_sat;
					qlvl_q    <= LW'(LOG);
					lvl_q     <= LW'(1);
					idx_q     <= '0;
					result_q  <= '0;
				end
			end
			ST_BUILD: begin
				wr_addr_q <= tbl_addr(lvl_q, idx_q);
				idx_q     <= last_i ? '0 : idx_q + AW'(1);
			end
			ST_GAP: begin
				if (lvl_q != LW'(LOG)) begin
					lvl_q <= lvl_q + LW'(1);
				end
			end
			ST_ISSUE: begin
				if (a_pend_q) begin
					min_q <= cmp_min;
				end
				if (a_take) begin
					pos_min_q <= pos_min_q + step;
				end
			end
			ST_DATA: begin
				// A whole window above the threshold is skipped.
				if (b_pend_q && !cmp_le) begin
					pos_dsc_q <= pos_dsc_q + step;
				end
				if (qlvl_q != '0) begin
					qlvl_q <= qlvl_q - LW'(1);
				end
			end
			ST_FOLD: begin
				result_q.found       <= (pos_dsc_q < e_q);
				result_q.first_index <= (pos_dsc_q < e_q) ? IDX_W'(pos_dsc_q) : '0;
				result_q.range_min   <= DATA_W'(a_pend_q ? cmp_min : min_q);
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hw/rtl/rfia_chk.sv @@
// Port-level checker for the range first-index-at-most block, bound to the top.
// Depends on rfia_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rfia_chk
	import rfia_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t request,
	input logic done,
	input rsp_t result
);

	`RFIA_ASSERT(a_miss_idx_zero, clk, arst_n, done && !result.found |-> result.first_index == '0, "first_index not zero on a miss")
	`RFIA_ASSERT(a_write_silent, clk, arst_n, start && !busy && request.action == ACT_WRITE |=> !done, "result after a write request")
	`RFIA_NEVER(a_done_busy, clk, arst_n, done && busy, "result strobe while busy")
	`RFIA_ASSERT(a_busy_ends, clk, arst_n, $fell(busy) |-> done, "busy dropped without a result")

endmodule

bind range_first_index_at_most rfia_chk u_rfia_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.done    (done),
	.result  (result)
);

@@ tb/range_first_index_at_most_test.sv @@
`timescale 1ns / 100ps
// Testbench for range_first_index_at_most: drives writes and range queries, predicts
// each answer by a direct scan of its own array copy, and checks every result.
// Depends on rfia_pkg and the range_first_index_at_most RTL.
module range_first_index_at_most_test
	import rfia_pkg::*;
();

	localparam int CELLS = 1024;
	localparam int QUIET_LIMIT = 60000;
	localparam int PHASES = 26;
	localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] MOST_POS = ~MOST_NEG;

	// Keeps a copy of the array, works out the answer of every accepted query
	// and holds those answers until the block delivers them.
	class range_query_ledger;
		logic signed [DATA_W-1:0] cells [CELLS];
		rsp_t owed [$];
		int mismatches = 0;

		function rsp_t scan_range(req_t r);
			rsp_t a;
			int lo, hi;
			logic signed [DATA_W-1:0] thr, low;
			a = '0;
			lo = int'(r.range_start);
			hi = int'(r.range_end);
			thr = r.threshold;
			if (hi > CELLS) hi = CELLS;
			if (lo > CELLS) lo = CELLS;
			if (lo < hi) begin
				low = cells[lo];
				for (int i = lo; i < hi; i++) begin
					if (cells[i] < low) low = cells[i];
					if (!a.found && cells[i] <= thr) begin
						a.found = 1'b1;
						a.first_index = IDX_W'(i);
					end
				end
				a.range_min = low;
			end
			return a;
		endfunction

		function void take_request(req_t r);
			if (r.action == ACT_WRITE)
				cells[r.element_index] = r.element_value;
			else
				owed = {owed, scan_range(r)};
		endfunction

		function int outstanding();
			return owed.size();
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("error at %0t: %s", $realtime, what);
		endtask

		task match_answer(rsp_t got);
			rsp_t want;
			if (owed.size() == 0) begin
				report_mismatch("result arrived with no query waiting");
				return;
			end
			want = owed.pop_front();
			if (got.found !== want.found)
				report_mismatch($sformatf("found %0b, expected %0b", got.found, want.found));
			if (got.first_index !== want.first_index)
				report_mismatch($sformatf("first_index %0d, expected %0d",
					got.first_index, want.first_index));
			if (got.range_min !== want.range_min)
				report_mismatch($sformatf("range_min %0d, expected %0d",
					got.range_min, want.range_min));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t request = '0;
	logic done;
	rsp_t result;

	range_query_ledger ledger;
	bit written [CELLS];
	bit steady = 1'b0;
	int quiet = 0;

	range_first_index_at_most #(.DEPTH(CELLS), .VALUE_WIDTH(DATA_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done) ledger.match_answer(result);
	end

	// Ends the run if neither a request nor a result moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	function automatic logic signed [DATA_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			case ($urandom_range(0, 3))
				0: return MOST_NEG;
				1: return MOST_POS;
				2: return '0;
				default: return '1;
			endcase
		end
		if (roll < 55) return int'($urandom_range(0, 100)) - 50;
		return $urandom;
	endfunction

	// Unused fields carry random bits so that every input bit moves.
	function automatic req_t filler();
		req_t r;
		r = req_t'({$urandom, $urandom, $urandom});
		r.range_end = END_W'($urandom_range(0, CELLS));
		return r;
	endfunction

	function automatic req_t write_req(input int idx, input logic signed [DATA_W-1:0] v);
		req_t r;
		r = filler();
		r.action = ACT_WRITE;
		r.element_index = IDX_W'(idx);
		r.element_value = v;
		return r;
	endfunction

	function automatic req_t query_req(input int s, input int e,
			input logic signed [DATA_W-1:0] thr);
		req_t r;
		r = filler();
		r.action = ACT_QUERY;
		r.range_start = IDX_W'(s);
		r.range_end = END_W'(e);
		r.threshold = thr;
		return r;
	endfunction

	function automatic int any_written_cell();
		int i;
		do i = $urandom_range(0, CELLS - 1); while (!written[i]);
		return i;
	endfunction

	// Queries never touch a cell that has not been written; empty and reversed
	// ranges read nothing, so they may point anywhere.
	function automatic req_t pick_query();
		int s, e, lim, roll;
		logic signed [DATA_W-1:0] thr;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			s = $urandom_range(0, CELLS - 1);
			e = $urandom_range(0, s);
		end else begin
			s = any_written_cell();
			lim = s;
			while (lim < CELLS && written[lim]) lim++;
			roll = $urandom_range(0, 99);
			if (roll < 30) e = lim;
			else if (roll < 45) e = s + 1;
			else e = $urandom_range(s + 1, lim);
		end
		roll = $urandom_range(0, 99);
		if (roll < 35 && s < e) thr = ledger.cells[$urandom_range(s, e - 1)];
		else if (roll < 45) thr = ($urandom_range(0, 1) != 0) ? MOST_NEG : MOST_POS;
		else thr = pick_value();
		return query_req(s, e, thr);
	endfunction

	// Called at a rising edge. Holds the request until it is taken, then either
	// keeps start high for the next one, idles at random before the next one, or waits
	// until every query answer has come back.
	task automatic send_request(input req_t r, input bit drain);
		start <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		ledger.take_request(r);
		if (r.action == ACT_WRITE) written[r.element_index] = 1'b1;
		if (drain || (!steady && $urandom_range(0, 99) < 11)) begin
			start <= 1'b0;
			if (drain) begin
				do @(posedge clk); while (ledger.outstanding() != 0);
			end else begin
				@(posedge clk);
			end
		end
	endtask

	initial begin
		int frontier, chunk, n;
		bit last;
		ledger = new;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extreme values, ties with the threshold, empty and
		// reversed ranges, the last cell, and a rebuild after a later write.
		send_request(write_req(0, 5), 1'b0);
		send_request(write_req(1, MOST_POS), 1'b0);
		send_request(write_req(2, -7), 1'b0);
		send_request(write_req(3, MOST_NEG), 1'b0);
		send_request(write_req(4, 0), 1'b0);
		send_request(write_req(5, -7), 1'b0);
		send_request(write_req(6, -1), 1'b0);
		send_request(write_req(7, 100), 1'b0);
		send_request(write_req(CELLS - 1, -1), 1'b0);
		send_request(query_req(0, 8, MOST_NEG), 1'b0);
		send_request(query_req(0, 8, MOST_POS), 1'b0);
		send_request(query_req(0, 3, -8), 1'b0);
		send_request(query_req(1, 2, MOST_POS - 1), 1'b0);
		send_request(query_req(2, 6, -7), 1'b0);
		send_request(query_req(4, 4, 0), 1'b0);
		send_request(query_req(6, 2, MOST_POS), 1'b0);
		send_request(query_req(0, 0, MOST_POS), 1'b0);
		send_request(query_req(CELLS - 1, 0, MOST_POS), 1'b0);
		send_request(query_req(CELLS - 1, CELLS, -1), 1'b0);
		send_request(query_req(7, 8, 99), 1'b0);
		send_request(write_req(CELLS - 1, MOST_POS), 1'b0);
		send_request(query_req(CELLS - 1, CELLS, 0), 1'b0);

		// Random part: phases extend the written prefix until it is full, rewrite
		// a few cells, then run a burst of queries, so every phase forces a rebuild.
		frontier = 8;
		for (int phase = 0; phase < PHASES; phase++) begin
			steady = (phase >= 6 && phase < 10);
			if (frontier < CELLS) begin
				chunk = $urandom_range(36, 52);
				if (chunk > CELLS - frontier) chunk = CELLS - frontier;
				for (int k = 0; k < chunk; k++) begin
					send_request(write_req(frontier, pick_value()), 1'b0);
					frontier++;
				end
				n = $urandom_range(0, 4);
			end else begin
				n = $urandom_range(1, 6);
			end
			for (int k = 0; k < n; k++)
				send_request(write_req(any_written_cell(), pick_value()), 1'b0);
			n = $urandom_range(10, 20);
			for (int k = 0; k < n; k++) begin
				last = (k == n - 1) && (phase % 5 == 2 || phase == PHASES - 1);
				send_request(pick_query(), last);
			end
		end

		repeat (30) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
